### design/rjb_pkg.sv
`timescale 1ns / 1ps
package rjb_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int SLOT_W    = 6;
    localparam int SEQ_W     = 16;
    localparam int RUN_W     = 7;
    localparam int THR_W     = 6;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_TAKE = 2'd1;
    localparam logic [1:0] OP_MARK = 2'd2;
    localparam logic [1:0] OP_TEAR = 2'd3;

    localparam logic [2:0] K_ACC   = 3'd0;
    localparam logic [2:0] K_DISC  = 3'd1;
    localparam logic [2:0] K_DELIV = 3'd2;
    localparam logic [2:0] K_UNDER = 3'd3;
    localparam logic [2:0] K_FLUSH = 3'd4;
    localparam logic [2:0] K_RTX   = 3'd5;
    localparam logic [2:0] K_DONE  = 3'd6;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [1:0] M_INIT  = 2'd0;
    localparam logic [1:0] M_FILL  = 2'd1;
    localparam logic [1:0] M_READY = 2'd2;

    localparam logic [SEQ_W-1:0] START_RST = 16'hFFFF;
    localparam logic [THR_W-1:0] THR_RST   = 6'd16;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SEQ_W-1:0] sequence_req;
    } t_in;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq_out;
        logic [RUN_W-1:0]  run_length;
        logic              use_silence;
        logic              became_ready;
        logic              last_result;
    } t_out;

endpackage

### design/rjb_front.sv
`timescale 1ns / 1ps
module rjb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rjb_pkg::t_in  i_item,
    output logic          o_cmd_valid,
    output rjb_pkg::t_in  o_cmd,
    input  logic          i_pop
);
    import rjb_pkg::*;

    t_in        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

### design/rjb_back.sv
`timescale 1ns / 1ps
module rjb_back #(
    parameter int SLOTS = rjb_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  rjb_pkg::t_in              i_cmd,
    output logic                      o_pop,
    input  logic [rjb_pkg::THR_W-1:0] i_thr,
    output logic                      o_valid,
    input  logic                      i_stall,
    output rjb_pkg::t_out             o_item
);
    import rjb_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SCAN0  = 5'd1;
    localparam logic [4:0] S_LOOP   = 5'd2;
    localparam logic [4:0] S_EVAL   = 5'd3;
    localparam logic [4:0] S_REQ    = 5'd4;
    localparam logic [4:0] S_CNT_RD = 5'd5;
    localparam logic [4:0] S_CNT_WR = 5'd6;
    localparam logic [4:0] S_CLS    = 5'd7;
    localparam logic [4:0] S_CLS1   = 5'd8;
    localparam logic [4:0] S_CLS2   = 5'd9;
    localparam logic [4:0] S_MM     = 5'd10;
    localparam logic [4:0] S_STORE  = 5'd11;
    localparam logic [4:0] S_SPAN0  = 5'd12;
    localparam logic [4:0] S_SPAN1  = 5'd13;
    localparam logic [4:0] S_SPAN2  = 5'd14;
    localparam logic [4:0] S_TK     = 5'd15;
    localparam logic [4:0] S_MISC   = 5'd16;

    logic [SEQ_W-1:0] m_seq [SLOTS];
    logic [1:0]       m_st  [SLOTS];
    logic [2:0]       m_cnt [SLOTS];

    logic [SLOTS-1:0] r_st_vld;
    logic [SLOTS-1:0] r_cnt_vld;
    logic [SLOTS-1:0] r_flush;

    logic [SEQ_W-1:0] r_seq_q;
    logic [1:0]       r_st_q;
    logic [2:0]       r_cnt_q;
    logic             r_st_vq;
    logic             r_cnt_vq;

    logic [4:0]       r_state;
    logic [1:0]       r_op;
    logic [SEQ_W-1:0] r_seq;
    logic [IW-1:0]    r_head;
    logic [IW-1:0]    r_tail;
    logic [1:0]       r_mode;
    logic [SEQ_W-1:0] r_start;
    logic [IW-1:0]    r_i;
    logic [CW-1:0]    r_steps;
    logic             r_open;
    logic             r_mi;
    logic             r_mnx;
    logic [IW-1:0]    r_first;
    logic [CW-1:0]    r_len;
    logic [IW-1:0]    r_j;
    logic [CW-1:0]    r_k;
    logic [SEQ_W-1:0] r_sh;
    logic             r_mvt;
    logic [SEQ_W-1:0] r_ma;
    logic [CW-1:0]    r_mn;
    logic             r_ov;
    t_out             r_out;

    logic [IW-1:0]    a_rd;
    logic             emit;
    t_out             e_out;
    logic             can_emit;
    logic             seq_we;
    logic [IW-1:0]    seq_wa;
    logic [SEQ_W-1:0] seq_wd;
    logic             st_we;
    logic [IW-1:0]    st_wa;
    logic [1:0]       st_wd;
    logic             cnt_we;
    logic [2:0]       cnt_wd;

    logic [1:0]       st_eff;
    logic [2:0]       cnt_eff;
    logic             miss_q;
    logic             open2;
    logic [CW-1:0]    len2;
    logic             is_init;
    logic [SEQ_W-1:0] d_i;
    logic [SEQ_W-1:0] fd;
    logic [SEQ_W-1:0] d_t;
    logic             disc;
    logic             need_mm;
    logic             mvt;
    logic [SEQ_W-1:0] mm_a_raw;
    logic [SEQ_W-1:0] mm_n16;
    logic [SEQ_W-1:0] mm_a;
    logic [CW-1:0]    mm_n;
    logic [SEQ_W-1:0] span;
    logic             rdy;
    logic [IW-1:0]    s_idx;

    assign st_eff   = r_st_vq ? r_st_q : ST_FREE;
    assign cnt_eff  = r_cnt_vq ? r_cnt_q : 3'd0;
    assign miss_q   = (st_eff == ST_MISS);
    assign open2    = r_open || r_mi;
    assign len2     = (r_open ? r_len : CW'(0)) + CW'(open2);
    assign is_init  = (r_mode == M_INIT);
    assign d_i      = r_seq - r_start;
    assign fd       = r_sh - r_seq;
    assign d_t      = r_seq - r_seq_q;
    assign disc     = is_init ? d_i[SEQ_W-1]
                              : ((fd != '0 && !fd[SEQ_W-1]) || d_t == '0);
    assign need_mm  = is_init ? (d_i != '0)
                              : (d_t != '0 && !d_t[SEQ_W-1] && d_t != 16'd1);
    assign mvt      = is_init || !d_t[SEQ_W-1];
    assign mm_a_raw = is_init ? r_start : r_seq_q + 16'd1;
    assign mm_n16   = r_seq - mm_a_raw;
    assign mm_a     = (mm_n16 > 16'(SLOTS)) ? r_seq - 16'(SLOTS) : mm_a_raw;
    assign mm_n     = (mm_n16 > 16'(SLOTS)) ? CW'(SLOTS) : mm_n16[CW-1:0];
    assign span     = r_seq_q - r_sh;
    assign rdy      = (r_mode == M_FILL) && (span >= {10'd0, i_thr});
    assign s_idx    = r_seq[IW-1:0];
    assign can_emit = !r_ov || !i_stall;
    assign cnt_wd   = (cnt_eff >= 3'd4) ? 3'd0 : cnt_eff + 3'd1;
    assign o_valid  = r_ov;
    assign o_item   = r_out;

    always_comb begin
        a_rd   = r_head;
        o_pop  = 1'b0;
        emit   = 1'b0;
        e_out  = '0;
        seq_we = 1'b0;
        seq_wa = s_idx;
        seq_wd = r_seq;
        st_we  = 1'b0;
        st_wa  = s_idx;
        st_wd  = ST_OK;
        cnt_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_cmd_valid;
            end
            S_LOOP: begin
                a_rd = r_i + IW'(1);
            end
            S_EVAL: begin
                a_rd = r_open ? r_first : r_i;
            end
            S_REQ: begin
                a_rd = r_first;
                if (cnt_eff == 3'd0) begin
                    emit             = can_emit;
                    e_out.kind       = K_RTX;
                    e_out.slot       = SLOT_W'(r_first);
                    e_out.seq_out    = r_seq_q;
                    e_out.run_length = RUN_W'(r_len);
                end
            end
            S_CNT_RD: begin
                a_rd = r_j;
            end
            S_CNT_WR: begin
                a_rd   = r_j;
                cnt_we = 1'b1;
            end
            S_CLS: begin
                a_rd = r_head;
            end
            S_CLS1, S_CLS2: begin
                a_rd = r_tail;
                if (r_state == S_CLS2) begin
                    if (disc) begin
                        emit              = can_emit;
                        e_out.kind        = K_DISC;
                        e_out.seq_out     = r_seq;
                        e_out.last_result = 1'b1;
                    end else if (is_init) begin
                        seq_we = 1'b1;
                        seq_wa = r_start[IW-1:0];
                        seq_wd = r_start;
                        st_we  = (d_i == '0);
                        st_wa  = r_start[IW-1:0];
                    end
                end
            end
            S_MM: begin
                seq_we = 1'b1;
                seq_wa = r_ma[IW-1:0];
                seq_wd = r_ma;
                st_we  = 1'b1;
                st_wa  = r_ma[IW-1:0];
                st_wd  = ST_MISS;
            end
            S_STORE: begin
                seq_we = 1'b1;
                st_we  = 1'b1;
            end
            S_SPAN0: begin
                a_rd = r_head;
            end
            S_SPAN1, S_SPAN2: begin
                a_rd = r_tail;
                if (r_state == S_SPAN2) begin
                    emit               = can_emit;
                    e_out.kind         = K_ACC;
                    e_out.slot         = SLOT_W'(s_idx);
                    e_out.seq_out      = r_seq;
                    e_out.became_ready = rdy;
                    e_out.last_result  = 1'b1;
                end
            end
            S_TK: begin
                a_rd              = r_head;
                emit              = can_emit;
                e_out.slot        = SLOT_W'(r_head);
                e_out.seq_out     = r_seq_q;
                e_out.last_result = 1'b1;
                if (r_flush[r_head]) begin
                    e_out.kind = K_FLUSH;
                end else if (st_eff == ST_FREE) begin
                    e_out.kind = K_UNDER;
                end else begin
                    e_out.kind        = K_DELIV;
                    e_out.use_silence = (st_eff == ST_MISS);
                end
            end
            S_MISC: begin
                emit              = can_emit;
                e_out.kind        = K_DONE;
                e_out.last_result = 1'b1;
                if (r_op == OP_MARK) begin
                    e_out.seq_out = r_seq;
                    if (!is_init) begin
                        e_out.slot = SLOT_W'(s_idx);
                    end
                end
            end
            default: begin
                a_rd = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            m_seq[seq_wa] <= seq_wd;
        end
        r_seq_q <= m_seq[a_rd];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_st[st_wa] <= st_wd;
        end
        r_st_q <= m_st[a_rd];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[r_j] <= cnt_wd;
        end
        r_cnt_q <= m_cnt[a_rd];
    end

    always_ff @(posedge i_clk) begin
        r_st_vq  <= r_st_vld[a_rd];
        r_cnt_vq <= r_cnt_vld[a_rd];
        if (emit) begin
            r_out <= e_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_st_vld  <= '0;
            r_cnt_vld <= '0;
            r_flush   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_mode    <= M_INIT;
            r_start   <= START_RST;
            r_ov      <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (st_we) begin
                r_st_vld[st_wa] <= 1'b1;
            end
            if (cnt_we) begin
                r_cnt_vld[r_j] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op    <= i_cmd.operation;
                        r_seq   <= i_cmd.sequence_req;
                        r_i     <= r_head;
                        r_steps <= '0;
                        r_open  <= 1'b0;
                        r_len   <= '0;
                        case (i_cmd.operation)
                            OP_PUT:  r_state <= S_SCAN0;
                            OP_TAKE: r_state <= S_TK;
                            default: r_state <= S_MISC;
                        endcase
                    end
                end
                S_SCAN0: begin
                    r_mi    <= miss_q;
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_i == r_tail || r_steps == CW'(SLOTS)) begin
                        r_state <= S_CLS;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_open && r_mi) begin
                        r_first <= r_i;
                    end
                    r_len <= len2;
                    if (open2 && !miss_q) begin
                        r_mnx   <= miss_q;
                        r_state <= S_REQ;
                    end else begin
                        r_open  <= open2;
                        r_i     <= r_i + IW'(1);
                        r_mi    <= miss_q;
                        r_steps <= r_steps + CW'(1);
                        r_state <= S_LOOP;
                    end
                end
                S_REQ: begin
                    if (cnt_eff != 3'd0 || can_emit) begin
                        r_j     <= r_first;
                        r_k     <= '0;
                        r_state <= S_CNT_RD;
                    end
                end
                S_CNT_RD: begin
                    r_state <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    r_j <= r_j + IW'(1);
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_len) begin
                        r_open  <= 1'b0;
                        r_i     <= r_i + IW'(1);
                        r_mi    <= r_mnx;
                        r_steps <= r_steps + CW'(1);
                        r_state <= S_LOOP;
                    end else begin
                        r_state <= S_CNT_RD;
                    end
                end
                S_CLS: begin
                    r_state <= S_CLS1;
                end
                S_CLS1: begin
                    r_sh    <= r_seq_q;
                    r_state <= S_CLS2;
                end
                S_CLS2: begin
                    if (disc) begin
                        if (can_emit) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (is_init) begin
                            r_head <= r_start[IW-1:0];
                        end
                        r_mvt   <= mvt;
                        r_ma    <= mm_a;
                        r_mn    <= mm_n;
                        r_state <= need_mm ? S_MM : S_STORE;
                    end
                end
                S_MM: begin
                    r_ma <= r_ma + 16'd1;
                    r_mn <= r_mn - CW'(1);
                    if (r_mn == CW'(1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (r_mvt) begin
                        r_tail <= s_idx;
                    end
                    if (is_init) begin
                        r_mode <= M_FILL;
                    end
                    r_state <= S_SPAN0;
                end
                S_SPAN0: begin
                    r_state <= S_SPAN1;
                end
                S_SPAN1: begin
                    r_sh    <= r_seq_q;
                    r_state <= S_SPAN2;
                end
                S_SPAN2: begin
                    if (can_emit) begin
                        if (rdy) begin
                            r_mode <= M_READY;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TK: begin
                    if (can_emit) begin
                        if (r_flush[r_head]) begin
                            r_mode          <= M_FILL;
                            r_flush[r_head] <= 1'b0;
                        end else if (st_eff == ST_FREE) begin
                            r_mode <= M_INIT;
                        end else begin
                            r_head            <= r_head + IW'(1);
                            r_st_vld[r_head]  <= 1'b0;
                            r_cnt_vld[r_head] <= 1'b0;
                            r_flush[r_head]   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MISC: begin
                    if (can_emit) begin
                        if (r_op == OP_MARK) begin
                            if (is_init) begin
                                r_start <= r_seq;
                            end else begin
                                r_flush[s_idx] <= 1'b1;
                            end
                        end else begin
                            r_mode    <= M_INIT;
                            r_head    <= '0;
                            r_tail    <= '0;
                            r_start   <= START_RST;
                            r_st_vld  <= '0;
                            r_cnt_vld <= '0;
                            r_flush   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### design/rtp_jitter_reorder_buffer.sv
`timescale 1ns / 1ps
// Metadata engine for a sequence-numbered packet ring of SLOTS slots.
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one command per
// item: put, take, start/flush mark or teardown. Output channel
// (o_out_valid / i_out_stall / o_out_item) returns one or more result items
// per command; last_result marks the final one.
// A two-entry command queue decouples the input from the executing
// sequencer, so up to two commands are taken while one is still at work.
// A put first walks the ring from head to tail, slot by slot; for each
// missing run it closes, it requests a retransmission if the first slot's
// count is zero and steps the count of every slot in the run. It then marks
// up to SLOTS slots of a gap as missing, classifies the packet and stores it.
// The output register holds a result while i_out_stall is high; the
// sequencer waits for it and loses nothing.
// Reset (synchronous, active low) empties the ring at once through per-slot
// valid bits, sets init mode, start sequence all ones and the start
// threshold to 16; no clearing pass is needed.
// start_threshold is written through the APB port at address 0.
module rtp_jitter_reorder_buffer #(
    parameter int SLOTS = rjb_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rjb_pkg::t_in   i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rjb_pkg::t_out  o_out_item,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import rjb_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             cmd_valid;
    t_in              cmd;
    logic             pop;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {26'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    rjb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    rjb_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_thr       (r_thr),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );
endmodule
